// File: hdl/sipsd_pkg.sv
// Package: shared constants, codes and types of the switched I/O pattern and SRAM device.
`default_nettype none

package sipsd_pkg;

  // Default sizes of the backup memory and its pointer
  localparam int SramDepthDefault   = 2048;
  localparam int PointerBitsDefault = 13;

  // Access kinds; any other code behaves as a peek
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PEEK  = 2'd2;

  // Register indexes
  localparam logic [3:0] IDX_ID      = 4'd0;
  localparam logic [3:0] IDX_STATUS  = 4'd1;
  localparam logic [3:0] IDX_COLOR   = 4'd3;
  localparam logic [3:0] IDX_PATTERN = 4'd4;
  localparam logic [3:0] IDX_PTR_LO  = 4'd7;
  localparam logic [3:0] IDX_PTR_HI  = 4'd8;
  localparam logic [3:0] IDX_DATA    = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRMWARE  = 2'd0;
  localparam logic [1:0] CFG_TURBO_AV  = 2'd1;
  localparam logic [1:0] CFG_SRAM      = 2'd2;

  // Byte values
  localparam logic [7:0] DEVICE_ID     = 8'h08;
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  // Result of one access as decided by the register block
  typedef struct packed {
    logic [7:0] reg_data;  // read byte when not served from memory
    logic       use_mem;   // take the byte from the memory read port
    logic       turbo;     // turbo flag after the access
  } acc_res_t;

endpackage

`default_nettype wire

// File: hdl/sipsd_sram.sv
// Backup memory: one synchronous port, write or registered read per cycle.
`default_nettype none

module sipsd_sram #(
  parameter int SRAM_DEPTH = sipsd_pkg::SramDepthDefault,
  parameter int ADDR_BITS  = 11
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [7:0]           wdata,
  output logic      [7:0]           rdata
);

  logic [7:0] mem [SRAM_DEPTH];
  logic [7:0] rdata_r;

  // Write at the addressed entry; register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/sipsd_regs.sv
// Register block: configuration, device state, access decode and memory requests.
`default_nettype none

module sipsd_regs #(
  parameter int SRAM_DEPTH   = sipsd_pkg::SramDepthDefault,
  parameter int POINTER_BITS = sipsd_pkg::PointerBitsDefault,
  parameter int ADDR_BITS    = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic                      cfg_data,
  input  wire logic                      acc,
  input  wire logic [1:0]                kind,
  input  wire logic [3:0]                reg_index,
  input  wire logic [7:0]                write_data,
  output sipsd_pkg::acc_res_t            res,
  output logic                           mem_we,
  output logic                           mem_re,
  output logic      [ADDR_BITS-1:0]      mem_addr,
  output logic      [7:0]                mem_wdata
);

  import sipsd_pkg::*;

  logic                    fw_r, fw_nxt;
  logic                    tav_r, tav_nxt;
  logic                    sram_r, sram_nxt;
  logic [3:0]              col_lo_r, col_lo_nxt;
  logic [3:0]              col_hi_r, col_hi_nxt;
  logic [7:0]              pat_r, pat_nxt;
  logic [POINTER_BITS-1:0] ptr_r, ptr_nxt;
  logic                    turbo_r, turbo_nxt;

  logic        is_write;
  logic        is_read;
  logic        hit;
  logic [31:0] ptr_ext;
  logic [15:0] ptr16;
  logic [7:0]  status;
  logic [7:0]  pixels;
  logic [7:0]  peek_data;

  assign is_write = (kind == KIND_WRITE);
  assign is_read  = (kind == KIND_READ);
  assign ptr_ext  = 32'(ptr_r);
  assign ptr16    = ptr_ext[15:0];
  assign hit      = sram_r && (ptr_ext < 32'(SRAM_DEPTH));

  // Status byte: switch, turbo available and turbo flag are active low
  assign status = {~fw_r, 4'b1111, ~tav_r, 1'b1, ~turbo_r};

  // Pixel pair from the top two pattern bits
  assign pixels = {pat_r[7] ? col_hi_r : col_lo_r, pat_r[6] ? col_hi_r : col_lo_r};

  // Read mux for non-memory registers
  always_comb begin
    unique case (reg_index)
      IDX_ID:     peek_data = ~DEVICE_ID;
      IDX_STATUS: peek_data = status;
      IDX_COLOR:  peek_data = pixels;
      default:    peek_data = UNMAPPED_BYTE;
    endcase
  end

  // Memory request for the data port
  assign mem_addr  = ptr_ext[ADDR_BITS-1:0];
  assign mem_wdata = write_data;
  assign mem_we    = acc && is_write && (reg_index == IDX_DATA) && hit;
  assign mem_re    = acc && !is_write && (reg_index == IDX_DATA) && hit;

  // Result of this access
  always_comb begin
    res.use_mem  = !is_write && (reg_index == IDX_DATA) && hit;
    res.reg_data = is_write ? 8'h00 : peek_data;
    res.turbo    = (is_write && (reg_index == IDX_STATUS)) ? ~write_data[0] : turbo_r;
  end

  // Next state of configuration and device registers
  always_comb begin
    fw_nxt     = fw_r;
    tav_nxt    = tav_r;
    sram_nxt   = sram_r;
    col_lo_nxt = col_lo_r;
    col_hi_nxt = col_hi_r;
    pat_nxt    = pat_r;
    ptr_nxt    = ptr_r;
    turbo_nxt  = turbo_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRMWARE: fw_nxt   = cfg_data;
        CFG_TURBO_AV: tav_nxt  = cfg_data;
        CFG_SRAM:     sram_nxt = cfg_data;
        default:      ;
      endcase
    end
    if (acc) begin
      if (is_write) begin
        unique case (reg_index)
          IDX_STATUS:  turbo_nxt = ~write_data[0];
          IDX_COLOR: begin
            col_hi_nxt = write_data[7:4];
            col_lo_nxt = write_data[3:0];
          end
          IDX_PATTERN: pat_nxt = write_data;
          IDX_PTR_LO:  ptr_nxt = POINTER_BITS'({ptr16[15:8], write_data});
          IDX_PTR_HI:  ptr_nxt = POINTER_BITS'({write_data, ptr16[7:0]});
          IDX_DATA:    ptr_nxt = ptr_r + 1'b1;
          default:     ;
        endcase
      end else if (is_read) begin
        unique case (reg_index)
          IDX_COLOR: pat_nxt = {pat_r[5:0], pat_r[7:6]};
          IDX_DATA:  ptr_nxt = ptr_r + 1'b1;
          default:   ;
        endcase
      end
    end
  end

  // Hold state; reset clears the control and device registers, except the SRAM bit, which it sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= 1'b0;
      tav_r    <= 1'b0;
      sram_r   <= 1'b1;
      col_lo_r <= '0;
      col_hi_r <= '0;
      pat_r    <= '0;
      ptr_r    <= '0;
      turbo_r  <= 1'b0;
    end else begin
      fw_r     <= fw_nxt;
      tav_r    <= tav_nxt;
      sram_r   <= sram_nxt;
      col_lo_r <= col_lo_nxt;
      col_hi_r <= col_hi_nxt;
      pat_r    <= pat_nxt;
      ptr_r    <= ptr_nxt;
      turbo_r  <= turbo_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/switched_io_pattern_sram_device_unit.sv
// Top level: stream ports, issue stage, output register and assertions.
//
//   channel | dir | beat contents (low bit first)
//   in_     | in  | kind[1:0], reg_index[5:2], write_data[13:6]
//   out_    | out | read_data[7:0], turbo_on[8]
//   cfg_    | in  | cfg_index selects register, cfg_data is its bit
//
// One beat per cycle when the output is drained; the memory is read at the accepting edge
// as the beat enters the issue stage, and the output register loads when the issue stage
// moves on; out_tvalid is the valid flag of that output register.
// The single memory port is used at most once per beat, at acceptance.
// Reset (rst_n low, synchronous) clears state and config, but sets the SRAM bit; memory is not cleared.
// A stalled output holds the issue stage, and in_tready drops while both are full and out_tready is low.
`default_nettype none

module switched_io_pattern_sram_device_unit #(
  parameter int SRAM_DEPTH   = sipsd_pkg::SramDepthDefault,
  parameter int POINTER_BITS = sipsd_pkg::PointerBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // kind[1:0], reg_index[5:2], write_data[13:6]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata   // read_data[7:0], turbo_on[8]
);

  import sipsd_pkg::*;

  localparam int AddrBits = (SRAM_DEPTH > 1) ? $clog2(SRAM_DEPTH) : 1;

  logic                acc;
  acc_res_t            res;
  logic                mem_we;
  logic                mem_re;
  logic [AddrBits-1:0] mem_addr;
  logic [7:0]          mem_wdata;
  logic [7:0]          mem_rdata;

  logic     s1_v_r, s1_v_nxt;
  acc_res_t s1_res_r;
  logic     out_v_r, out_v_nxt;
  logic [7:0] out_data_r;
  logic       out_turbo_r;
  logic       s1_move;

  // Advance the issue stage when the output register is free or drains
  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_move;
  assign acc       = in_tvalid && in_tready;

  sipsd_regs #(
    .SRAM_DEPTH  (SRAM_DEPTH),
    .POINTER_BITS(POINTER_BITS),
    .ADDR_BITS   (AddrBits)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .kind      (in_tdata[1:0]),
    .reg_index (in_tdata[5:2]),
    .write_data(in_tdata[13:6]),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  sipsd_sram #(
    .SRAM_DEPTH(SRAM_DEPTH),
    .ADDR_BITS (AddrBits)
  ) u_sram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Valid flags of the issue stage and the output register
  always_comb begin
    s1_v_nxt  = acc ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
    out_v_nxt = s1_move ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload: capture the access result, then pick memory or register byte
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
    if (s1_move) begin
      out_data_r  <= s1_res_r.use_mem ? mem_rdata : s1_res_r.reg_data;
      out_turbo_r <= s1_res_r.turbo;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_turbo_r, out_data_r};

`ifndef SYNTHESIS
  // A full issue stage behind a stalled output blocks new beats
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("beat accepted while issue stage is blocked");

  // Memory is touched only by an accepted beat
  a_mem_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we || mem_re) |-> (in_tvalid && in_tready))
    else $error("memory access without an accepted beat");

  // An issued beat is never dropped before it moves to the output
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_move) |=> s1_v_r)
    else $error("issue stage lost a beat");
`endif

endmodule

`default_nettype wire

// File: dv/switched_io_pattern_sram_device_unit_tb.sv
// Self-checking testbench for the switched I/O pattern and backup SRAM device.
module switched_io_pattern_sram_device_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sipsd_pkg::*;

  localparam int DEPTH  = SramDepthDefault;
  localparam int PTR_W  = PointerBitsDefault;
  localparam int ADDR_W = $clog2(DEPTH);

  // Odd access kind and two unmapped indexes used by the directed rows
  localparam logic [1:0] KIND_OTHER   = 2'd3;
  localparam logic [3:0] IDX_UNUSED   = 4'd2;
  localparam logic [3:0] IDX_TOP      = 4'd15;
  localparam int         BEATS_PER_PHASE = 215;

  typedef struct packed {
    logic [7:0] rd;
    logic       turbo;
  } reply_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
    logic [7:0] wdata;
    logic       pinned;  // expected reply typed in below
    logic [7:0] rd;
    logic       turbo;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FIRMWARE;
  logic        cfg_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // kind[1:0], reg_index[5:2], write_data[13:6]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // read_data[7:0], turbo_on[8]

  // Device state as the predictor sees it
  logic [3:0]       col_lo, col_hi;
  logic [7:0]       pattern;
  logic [PTR_W-1:0] mem_ptr;
  logic             turbo;
  logic [7:0]       mem [0:DEPTH-1];
  bit               mem_seen [0:DEPTH-1];
  logic             fw_sw, turbo_av, sram_fit;

  reply_t expected_replies[$];
  reply_t want;
  int     mismatches = 0;
  bit     in_gaps = 1'b1;
  bit     out_gaps = 1'b1;

  dir_row_t dir_rows [25] = '{
    '{KIND_READ,  IDX_ID,      8'h00, 1'b1, 8'hF7, 1'b0},
    '{KIND_PEEK,  IDX_STATUS,  8'hFF, 1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, IDX_STATUS,  8'h00, 1'b1, 8'h00, 1'b1},
    '{KIND_READ,  IDX_STATUS,  8'h00, 1'b0, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_STATUS,  8'hFF, 1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_COLOR,   8'hA5, 1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_PATTERN, 8'hB4, 1'b1, 8'h00, 1'b0},
    '{KIND_READ,  IDX_COLOR,   8'h00, 1'b0, 8'h00, 1'b0},
    '{KIND_PEEK,  IDX_COLOR,   8'h00, 1'b0, 8'h00, 1'b0},
    '{KIND_OTHER, IDX_COLOR,   8'hFF, 1'b0, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_PTR_LO,  8'hFF, 1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_PTR_HI,  8'h07, 1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_DATA,    8'h5A, 1'b1, 8'h00, 1'b0},
    '{KIND_READ,  IDX_DATA,    8'h00, 1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, IDX_PTR_LO,  8'hFF, 1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_PTR_HI,  8'hFF, 1'b1, 8'h00, 1'b0},
    '{KIND_READ,  IDX_DATA,    8'h00, 1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, IDX_DATA,    8'h00, 1'b1, 8'h00, 1'b0},
    '{KIND_WRITE, IDX_PTR_LO,  8'h00, 1'b1, 8'h00, 1'b0},
    '{KIND_PEEK,  IDX_DATA,    8'h00, 1'b0, 8'h00, 1'b0},
    '{KIND_READ,  IDX_DATA,    8'h00, 1'b0, 8'h00, 1'b0},
    '{KIND_READ,  IDX_TOP,     8'h00, 1'b1, 8'hFF, 1'b0},
    '{KIND_WRITE, IDX_ID,      8'hFF, 1'b1, 8'h00, 1'b0},
    '{KIND_PEEK,  IDX_UNUSED,  8'h00, 1'b1, 8'hFF, 1'b0},
    '{KIND_OTHER, IDX_TOP,     8'hFF, 1'b1, 8'hFF, 1'b0}
  };

  switched_io_pattern_sram_device_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one bus access to the predicted device state and return its reply
  function automatic void bus_access_result(input logic [1:0] k, input logic [3:0] idx,
                                            input logic [7:0] wd, output logic [7:0] rd,
                                            output logic tb);
    logic hit;
    hit = sram_fit && (mem_ptr < DEPTH);
    rd = 8'h00;
    if (k == KIND_WRITE) begin
      case (idx)
        IDX_STATUS:  turbo = ~wd[0];
        IDX_COLOR: begin
          col_hi = wd[7:4];
          col_lo = wd[3:0];
        end
        IDX_PATTERN: pattern = wd;
        IDX_PTR_LO:  mem_ptr[7:0] = wd;
        IDX_PTR_HI:  mem_ptr[PTR_W-1:8] = wd[PTR_W-9:0];
        IDX_DATA: begin
          if (hit) begin
            mem[mem_ptr[ADDR_W-1:0]] = wd;
            mem_seen[mem_ptr[ADDR_W-1:0]] = 1'b1;
          end
          mem_ptr = mem_ptr + 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (idx)
        IDX_ID:     rd = ~DEVICE_ID;
        IDX_STATUS: rd = {~fw_sw, 4'hF, ~turbo_av, 1'b1, ~turbo};
        IDX_COLOR: begin
          rd = {pattern[7] ? col_hi : col_lo, pattern[6] ? col_hi : col_lo};
          if (k == KIND_READ) pattern = {pattern[5:0], pattern[7:6]};
        end
        IDX_DATA: begin
          rd = hit ? mem[mem_ptr[ADDR_W-1:0]] : UNMAPPED_BYTE;
          if (k == KIND_READ) mem_ptr = mem_ptr + 1'b1;
        end
        default: rd = UNMAPPED_BYTE;
      endcase
    end
    tb = turbo;
  endfunction

  // Predict one access, queue its reply, then hold the beat until accepted
  task automatic send_access(input logic [1:0] k, input logic [3:0] idx, input logic [7:0] wd,
                             input logic pinned, input logic [7:0] pin_rd,
                             input logic pin_tb);
    reply_t exp_reply;
    logic [7:0] rd;
    logic tb;
    // never read a memory cell that was never written: turn it into a write
    if (k != KIND_WRITE && idx == IDX_DATA && sram_fit && mem_ptr < DEPTH &&
        !mem_seen[mem_ptr[ADDR_W-1:0]])
      k = KIND_WRITE;
    bus_access_result(k, idx, wd, rd, tb);
    exp_reply.rd = pinned ? pin_rd : rd;
    exp_reply.turbo = pinned ? pin_tb : tb;
    expected_replies.push_back(exp_reply);
    @(negedge clk);
    while (in_gaps && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, wd, idx, k};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every queued reply has come back
  task automatic drain_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic fw, input logic tav, input logic sram);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIRMWARE;
    cfg_data <= fw;
    @(negedge clk);
    cfg_index <= CFG_TURBO_AV;
    cfg_data <= tav;
    @(negedge clk);
    cfg_index <= CFG_SRAM;
    cfg_data <= sram;
    @(negedge clk);
    cfg_we <= 1'b0;
    fw_sw = fw;
    turbo_av = tav;
    sram_fit = sram;
  endtask

  // Mostly well-formed memory bursts and pattern runs, the rest noise
  task automatic run_phase(input int n_items);
    int sent;
    int n;
    int pick;
    logic [PTR_W-1:0] base;
    logic [2:0] junk;
    logic [1:0] k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 9))
          0:       base = PTR_W'(DEPTH - 1 - int'($urandom_range(0, 7)));
          1:       base = {PTR_W{1'b1}} - PTR_W'($urandom_range(0, 7));
          2:       base = PTR_W'($urandom);
          default: base = PTR_W'($urandom_range(0, 63));
        endcase
        n = $urandom_range(1, 8);
        junk = 3'($urandom);
        send_access(KIND_WRITE, IDX_PTR_LO, base[7:0], 1'b0, 8'h00, 1'b0);
        send_access(KIND_WRITE, IDX_PTR_HI, {junk, base[12:8]}, 1'b0, 8'h00, 1'b0);
        for (int i = 0; i < n; i++)
          send_access(KIND_WRITE, IDX_DATA, 8'($urandom), 1'b0, 8'h00, 1'b0);
        send_access(KIND_WRITE, IDX_PTR_LO, base[7:0], 1'b0, 8'h00, 1'b0);
        send_access(KIND_WRITE, IDX_PTR_HI, {3'b000, base[12:8]}, 1'b0, 8'h00, 1'b0);
        for (int i = 0; i < n; i++) begin
          k = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(2, 3)) : KIND_READ;
          send_access(k, IDX_DATA, 8'($urandom), 1'b0, 8'h00, 1'b0);
        end
        sent += 4 + 2 * n;
      end else if (pick < 55) begin
        n = $urandom_range(1, 6);
        send_access(KIND_WRITE, IDX_COLOR, 8'($urandom), 1'b0, 8'h00, 1'b0);
        send_access(KIND_WRITE, IDX_PATTERN, 8'($urandom), 1'b0, 8'h00, 1'b0);
        for (int i = 0; i < n; i++) begin
          k = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(2, 3)) : KIND_READ;
          send_access(k, IDX_COLOR, 8'($urandom), 1'b0, 8'h00, 1'b0);
        end
        sent += 2 + n;
      end else if (pick < 65) begin
        send_access(KIND_WRITE, IDX_STATUS, 8'($urandom), 1'b0, 8'h00, 1'b0);
        send_access(2'($urandom_range(1, 3)), IDX_STATUS, 8'($urandom),
                    1'b0, 8'h00, 1'b0);
        sent += 2;
      end else begin
        send_access(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 8'($urandom),
                    1'b0, 8'h00, 1'b0);
        sent += 1;
      end
    end
  endtask

  // Receiver: stall at random while gaps are enabled
  always @(negedge clk) begin
    out_tready <= out_gaps ? ($urandom_range(0, 99) >= 16) : 1'b1;
  end

  // Compare each accepted reply with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply with nothing expected: read_data=%h turbo_on=%b",
                   out_tdata[7:0], out_tdata[8]);
      end else begin
        want = expected_replies.pop_front();
        if (out_tdata[7:0] !== want.rd || out_tdata[8] !== want.turbo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: read_data exp %h got %h, turbo_on exp %b got %b",
                     want.rd, out_tdata[7:0], want.turbo, out_tdata[8]);
        end
      end
    end
  end

  initial begin
    logic [2:0] phase_cfg [6];
    phase_cfg = '{3'b111, 3'b000, 3'b101, 3'b010, 3'b100, 3'b011};
    col_lo = '0;
    col_hi = '0;
    pattern = '0;
    mem_ptr = '0;
    turbo = 1'b0;
    fw_sw = 1'b0;
    turbo_av = 1'b0;
    sram_fit = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows with the reset configuration
    foreach (dir_rows[i])
      send_access(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].wdata,
                  dir_rows[i].pinned, dir_rows[i].rd, dir_rows[i].turbo);
    drain_replies();

    // Random phases; bits of each setting are {fw, tav, sram}
    foreach (phase_cfg[p]) begin
      in_gaps = (p != 3);
      out_gaps = (p != 3);
      write_config(phase_cfg[p][2], phase_cfg[p][1], phase_cfg[p][0]);
      run_phase(BEATS_PER_PHASE);
      drain_replies();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
